>>> rtl/reader_writer_request_queue_core_assert.svh
// Assertion macros shared by the request queue RTL.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef READER_WRITER_REQUEST_QUEUE_CORE_ASSERT_SVH
`define READER_WRITER_REQUEST_QUEUE_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// The expression holds at every clock edge outside reset.
`define RWQ_ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define RWQ_ASSERT_WHEN(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Whenever the antecedent holds, the consequent holds in the next cycle.
`define RWQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define RWQ_ASSERT_ALWAYS(lbl, expr, msg)
`define RWQ_ASSERT_WHEN(lbl, ante, cons, msg)
`define RWQ_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

>>> rtl/rwq_pkg.sv
`default_nettype none

package rwq_pkg;

    localparam int DEPTH         = 64;
    localparam int PAYLOAD_WIDTH = 32;
    localparam int MAX_BURST     = 16;

    localparam int AW      = $clog2(DEPTH);
    localparam int CW      = $clog2(DEPTH + 1);
    localparam int LW      = $clog2(MAX_BURST + 1);
    localparam int KIND_W  = 2;
    localparam int ENTRY_W = KIND_W + PAYLOAD_WIDTH;

    // Entry kinds.
    localparam logic [1:0] KIND_EXCL  = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    // Request operations.
    localparam logic [1:0] OP_PUSH = 2'd0;
    localparam logic [1:0] OP_PULL = 2'd1;
    localparam logic [1:0] OP_SET  = 2'd2;

    // Service states.
    localparam logic [1:0] SVC_IDLE  = 2'd0;
    localparam logic [1:0] SVC_LOCK  = 2'd1;
    localparam logic [1:0] SVC_READ  = 2'd2;
    localparam logic [1:0] SVC_WRITE = 2'd3;

    // Queue modes.
    localparam logic [1:0] MODE_EXCL    = 2'd0;
    localparam logic [1:0] MODE_INORDER = 2'd1;
    localparam logic [1:0] MODE_WFIRST  = 2'd2;

    // Result status codes.
    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_FULL  = 3'd1;
    localparam logic [2:0] STAT_NONE  = 3'd2;
    localparam logic [2:0] STAT_KIND  = 3'd3;
    localparam logic [2:0] STAT_STATE = 3'd4;

    // Configuration register indexes.
    localparam logic CFG_QUEUE_MODE = 1'b0;
    localparam logic CFG_SLOT_LIMIT = 1'b1;
    localparam int   CFG_DATA_W     = 7;

    typedef enum logic [3:0] {
        FSM_IDLE  = 4'b0001,
        FSM_EXEC  = 4'b0010,
        FSM_READ  = 4'b0100,
        FSM_CHECK = 4'b1000
    } fsm_t;

    // One memory port group: a write port and a read port.
    typedef struct packed {
        logic               we;
        logic [AW-1:0]      waddr;
        logic [ENTRY_W-1:0] wdata;
        logic               re;
        logic [AW-1:0]      raddr;
    } mem_req_t;

endpackage

`default_nettype wire

>>> rtl/rwq_ram.sv
`default_nettype none

module rwq_ram #(
    parameter int WIDTH = 34,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> rtl/rwq_ctrl.sv
`default_nettype none

`include "reader_writer_request_queue_core_assert.svh"

module rwq_ctrl
    import rwq_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output      logic                     in_stall,
    input  wire logic [1:0]               op,
    input  wire logic [1:0]               elem_kind,
    input  wire logic [31:0]              payload,
    input  wire logic [4:0]               max_pull,
    input  wire logic [1:0]               new_state,
    output      logic                     out_valid,
    input  wire logic                     out_stall,
    output      logic [1:0]               out_kind,
    output      logic [31:0]              out_payload,
    output      logic                     item_valid,
    output      logic [2:0]               status,
    output      logic                     last,
    input  wire logic                     cfg_we,
    input  wire logic                     cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    output      mem_req_t                 main_req,
    input  wire logic [ENTRY_W-1:0]       main_rdata,
    output      mem_req_t                 wr_req,
    input  wire logic [ENTRY_W-1:0]       wr_rdata
);

    fsm_t state_reg, state_next;

    logic [1:0]    mode_reg;
    logic [6:0]    slot_reg;
    logic [1:0]    svc_reg, svc_next;
    logic [AW-1:0] main_head_reg, main_head_next;
    logic [CW-1:0] main_count_reg, main_count_next;
    logic [AW-1:0] wr_head_reg, wr_head_next;
    logic [CW-1:0] wr_count_reg, wr_count_next;

    logic [1:0]  op_reg, kind_reg, ns_reg;
    logic [31:0] pay_reg;
    logic [4:0]  maxp_reg;

    logic          src_reg, src_next;
    logic          any_reg, any_next;
    logic [LW-1:0] limit_reg, limit_next;
    logic [LW-1:0] taken_reg, taken_next;
    logic          held_valid_reg, held_valid_next;
    logic [ENTRY_W-1:0] held_reg, held_next;

    logic        out_valid_reg, out_valid_next;
    logic [1:0]  out_kind_reg, out_kind_next;
    logic [31:0] out_pay_reg, out_pay_next;
    logic        item_valid_reg, item_valid_next;
    logic [2:0]  status_reg, status_next;
    logic        last_reg, last_next;

    logic [CW-1:0]      eff_slots;
    logic [6:0]         lim_wide;
    logic [LW-1:0]      pull_limit;
    logic               out_free;
    logic [CW-1:0]      cur_count;
    logic [AW-1:0]      cur_head;
    logic [ENTRY_W-1:0] rdata;
    logic [1:0]         rd_kind;
    logic               match;
    logic               push_main, push_wr;
    logic               set_ok;

    assign in_stall    = (state_reg != FSM_IDLE);
    assign out_valid   = out_valid_reg;
    assign out_kind    = out_kind_reg;
    assign out_payload = out_pay_reg;
    assign item_valid  = item_valid_reg;
    assign status      = status_reg;
    assign last        = last_reg;

    assign out_free = !out_valid_reg || !out_stall;

    // A slot limit of zero counts as one; anything above the depth is clamped.
    always_comb
    begin
        if (slot_reg == 7'd0)
        begin
            eff_slots = CW'(1);
        end
        else if (CW'(slot_reg) > CW'(DEPTH) || slot_reg > 7'(DEPTH))
        begin
            eff_slots = CW'(DEPTH);
        end
        else
        begin
            eff_slots = CW'(slot_reg);
        end
    end

    always_comb
    begin
        lim_wide = {2'b00, maxp_reg};
        if (lim_wide > 7'(eff_slots))
        begin
            lim_wide = 7'(eff_slots);
        end
        if (lim_wide > 7'(MAX_BURST))
        begin
            lim_wide = 7'(MAX_BURST);
        end
        pull_limit = LW'(lim_wide);
    end

    assign cur_count = src_reg ? wr_count_reg : main_count_reg;
    assign cur_head  = src_reg ? wr_head_reg : main_head_reg;
    assign rdata     = src_reg ? wr_rdata : main_rdata;
    assign rd_kind   = rdata[ENTRY_W-1 -: KIND_W];
    assign match     = any_reg || (rd_kind == (src_reg ? KIND_WRITE : KIND_READ));

    // Decode of where a push lands and whether a new service state is taken.
    always_comb
    begin
        push_main = 1'b0;
        push_wr   = 1'b0;
        set_ok    = 1'b0;
        unique case (mode_reg)
            MODE_EXCL:
            begin
                push_main = (kind_reg == KIND_EXCL);
                set_ok    = (ns_reg == SVC_IDLE) || (ns_reg == SVC_LOCK);
            end
            MODE_INORDER:
            begin
                push_main = (kind_reg == KIND_READ) || (kind_reg == KIND_WRITE);
                set_ok    = (ns_reg != SVC_LOCK);
            end
            MODE_WFIRST:
            begin
                push_main = (kind_reg == KIND_READ);
                push_wr   = (kind_reg == KIND_WRITE);
                set_ok    = (ns_reg != SVC_LOCK);
            end
            default:
            begin
                push_main = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        svc_next        = svc_reg;
        main_head_next  = main_head_reg;
        main_count_next = main_count_reg;
        wr_head_next    = wr_head_reg;
        wr_count_next   = wr_count_reg;
        src_next        = src_reg;
        any_next        = any_reg;
        limit_next      = limit_reg;
        taken_next      = taken_reg;
        held_valid_next = held_valid_reg;
        held_next       = held_reg;

        out_valid_next  = out_valid_reg && out_stall;
        out_kind_next   = out_kind_reg;
        out_pay_next    = out_pay_reg;
        item_valid_next = item_valid_reg;
        status_next     = status_reg;
        last_next       = last_reg;

        main_req = '0;
        wr_req   = '0;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = FSM_EXEC;
                end
            end

            FSM_EXEC:
            begin
                if (op_reg == OP_PULL)
                begin
                    taken_next      = '0;
                    held_valid_next = 1'b0;
                    src_next        = 1'b0;
                    any_next        = 1'b0;
                    limit_next      = pull_limit;
                    unique case (mode_reg)
                        MODE_EXCL:
                        begin
                            any_next   = 1'b1;
                            limit_next = (svc_reg != SVC_LOCK && pull_limit != '0)
                                         ? LW'(1) : '0;
                        end
                        MODE_INORDER:
                        begin
                            if (svc_reg == SVC_IDLE)
                            begin
                                any_next = 1'b1;
                            end
                            else if (svc_reg != SVC_READ)
                            begin
                                limit_next = '0;
                            end
                        end
                        MODE_WFIRST:
                        begin
                            src_next = (wr_count_reg != '0);
                        end
                        default:
                        begin
                            limit_next = '0;
                        end
                    endcase
                    state_next = FSM_READ;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = KIND_EXCL;
                    out_pay_next    = '0;
                    item_valid_next = 1'b0;
                    last_next       = 1'b1;
                    status_next     = STAT_OK;
                    if (op_reg == OP_PUSH)
                    begin
                        if (push_main)
                        begin
                            if (main_count_reg >= eff_slots)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                main_req.we     = 1'b1;
                                main_req.waddr  = main_head_reg + AW'(main_count_reg);
                                main_req.wdata  = {kind_reg, pay_reg};
                                main_count_next = main_count_reg + CW'(1);
                            end
                        end
                        else if (push_wr)
                        begin
                            if (wr_count_reg >= eff_slots)
                            begin
                                status_next = STAT_FULL;
                            end
                            else
                            begin
                                wr_req.we     = 1'b1;
                                wr_req.waddr  = wr_head_reg + AW'(wr_count_reg);
                                wr_req.wdata  = {kind_reg, pay_reg};
                                wr_count_next = wr_count_reg + CW'(1);
                            end
                        end
                        else
                        begin
                            status_next = STAT_KIND;
                        end
                    end
                    else if (op_reg == OP_SET)
                    begin
                        if (set_ok)
                        begin
                            svc_next = ns_reg;
                        end
                        else
                        begin
                            status_next = STAT_STATE;
                        end
                    end
                    else
                    begin
                        status_next = STAT_KIND;
                    end
                    state_next = FSM_IDLE;
                end
            end

            FSM_READ:
            begin
                if (taken_reg < limit_reg && cur_count != '0)
                begin
                    main_req.re    = !src_reg;
                    main_req.raddr = cur_head;
                    wr_req.re      = src_reg;
                    wr_req.raddr   = cur_head;
                    state_next     = FSM_CHECK;
                end
                else if (out_free)
                begin
                    // The run is over: release the held entry as the final
                    // result, or report that nothing was pulled.
                    out_valid_next  = 1'b1;
                    last_next       = 1'b1;
                    item_valid_next = held_valid_reg;
                    if (held_valid_reg)
                    begin
                        out_kind_next = held_reg[ENTRY_W-1 -: KIND_W];
                        out_pay_next  = held_reg[PAYLOAD_WIDTH-1:0];
                        status_next   = STAT_OK;
                    end
                    else
                    begin
                        out_kind_next = KIND_EXCL;
                        out_pay_next  = '0;
                        status_next   = STAT_NONE;
                    end
                    held_valid_next = 1'b0;
                    state_next      = FSM_IDLE;
                end
            end

            FSM_CHECK:
            begin
                if (match)
                begin
                    if (!held_valid_reg || out_free)
                    begin
                        if (held_valid_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_kind_next   = held_reg[ENTRY_W-1 -: KIND_W];
                            out_pay_next    = held_reg[PAYLOAD_WIDTH-1:0];
                            item_valid_next = 1'b1;
                            status_next     = STAT_OK;
                            last_next       = 1'b0;
                        end
                        held_valid_next = 1'b1;
                        held_next       = rdata;
                        taken_next      = taken_reg + LW'(1);
                        any_next        = 1'b0;
                        if (src_reg)
                        begin
                            wr_head_next  = wr_head_reg + AW'(1);
                            wr_count_next = wr_count_reg - CW'(1);
                        end
                        else
                        begin
                            main_head_next  = main_head_reg + AW'(1);
                            main_count_next = main_count_reg - CW'(1);
                        end
                        // A write, or a first entry that is not a read, ends the run.
                        if (src_reg || (any_reg && rd_kind != KIND_READ))
                        begin
                            limit_next = taken_reg + LW'(1);
                        end
                        state_next = FSM_READ;
                    end
                end
                else
                begin
                    if (src_reg && taken_reg == '0)
                    begin
                        src_next = 1'b0;
                    end
                    else
                    begin
                        limit_next = taken_reg;
                    end
                    state_next = FSM_READ;
                end
            end

            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= FSM_IDLE;
            svc_reg        <= SVC_IDLE;
            main_head_reg  <= '0;
            main_count_reg <= '0;
            wr_head_reg    <= '0;
            wr_count_reg   <= '0;
            src_reg        <= 1'b0;
            any_reg        <= 1'b0;
            limit_reg      <= '0;
            taken_reg      <= '0;
            held_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            svc_reg        <= svc_next;
            main_head_reg  <= main_head_next;
            main_count_reg <= main_count_next;
            wr_head_reg    <= wr_head_next;
            wr_count_reg   <= wr_count_next;
            src_reg        <= src_next;
            any_reg        <= any_next;
            limit_reg      <= limit_next;
            taken_reg      <= taken_next;
            held_valid_reg <= held_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EXCL;
            slot_reg <= 7'(DEPTH);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_QUEUE_MODE: mode_reg <= cfg_data[1:0];
                CFG_SLOT_LIMIT: slot_reg <= cfg_data[6:0];
                default:        mode_reg <= mode_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == FSM_IDLE && in_valid)
        begin
            op_reg   <= op;
            kind_reg <= elem_kind;
            pay_reg  <= payload;
            maxp_reg <= max_pull;
            ns_reg   <= new_state;
        end
        held_reg       <= held_next;
        out_kind_reg   <= out_kind_next;
        out_pay_reg    <= out_pay_next;
        item_valid_reg <= item_valid_next;
        status_reg     <= status_next;
        last_reg       <= last_next;
    end

    `RWQ_ASSERT_ALWAYS(a_count_bound, main_count_reg <= CW'(DEPTH) && wr_count_reg <= CW'(DEPTH), "queue count beyond depth")
    `RWQ_ASSERT_ALWAYS(a_taken_bound, taken_reg <= limit_reg, "more entries taken than the pull limit")
    `RWQ_ASSERT_NEXT(a_accept_exec, in_valid && !in_stall, state_reg == FSM_EXEC, "accepted request not executed")
    `RWQ_ASSERT_WHEN(a_entry_ok, out_valid_reg && item_valid_reg, status_reg == STAT_OK, "pulled entry without ok status")

endmodule

`default_nettype wire

>>> rtl/reader_writer_request_queue_core.sv
// Typed request queue for a readers-writer scheduler.
// Requests enter on the input channel (in_valid, in_stall) and carry an
// operation: push an entry, pull entries, or set the service state.
// Results leave on the output channel (out_valid, out_stall); every request
// gives one or more results and the final one carries last.
// Configuration (queue_mode, slot_limit) is written through cfg_we, cfg_index
// and cfg_data while no request is in flight.
// Sequencing: one request is handled at a time. A push or a set has its
// result written to the output register once that register is free.
// A pull examines entries one by one: each entry is one read of the queue
// memory followed by a check of its kind, and the final result is written
// after the last entry examined. A write-first pull picks its queue from
// the counts, so it reads no extra entry.
// Reset clears the heads, counts and service state (idle), sets exclusive
// mode and a slot limit of 64; the memories need no clearing.
// When the receiver stalls, the result waits in the output register and the
// pull holds its next entry until there is room; nothing is dropped.
`default_nettype none

module reader_writer_request_queue_core
    import rwq_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output      logic                  in_stall,
    input  wire logic [1:0]            op,
    input  wire logic [1:0]            elem_kind,
    input  wire logic [31:0]           payload,
    input  wire logic [4:0]            max_pull,
    input  wire logic [1:0]            new_state,
    output      logic                  out_valid,
    input  wire logic                  out_stall,
    output      logic [1:0]            out_kind,
    output      logic [31:0]           out_payload,
    output      logic                  item_valid,
    output      logic [2:0]            status,
    output      logic                  last,
    input  wire logic                  cfg_we,
    input  wire logic                  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Port groups of the main queue memory and of the write queue memory.
    mem_req_t           main_req;
    mem_req_t           wr_req;
    logic [ENTRY_W-1:0] main_rdata;
    logic [ENTRY_W-1:0] wr_rdata;

    // The main queue holds exclusive and read entries, and writes too
    // outside write-first mode.
    rwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_main_ram (
        .clk   (clk),
        .we    (main_req.we),
        .waddr (main_req.waddr),
        .wdata (main_req.wdata),
        .re    (main_req.re),
        .raddr (main_req.raddr),
        .rdata (main_rdata)
    );

    // The write queue is only used in write-first mode, where it is served
    // ahead of the reads.
    rwq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_wr_ram (
        .clk   (clk),
        .we    (wr_req.we),
        .waddr (wr_req.waddr),
        .wdata (wr_req.wdata),
        .re    (wr_req.re),
        .raddr (wr_req.raddr),
        .rdata (wr_rdata)
    );

    // The controller sequences each request, owns the queue pointers and the
    // service state, and holds the output register.
    rwq_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .elem_kind   (elem_kind),
        .payload     (payload),
        .max_pull    (max_pull),
        .new_state   (new_state),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .out_payload (out_payload),
        .item_valid  (item_valid),
        .status      (status),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .main_req    (main_req),
        .main_rdata  (main_rdata),
        .wr_req      (wr_req),
        .wr_rdata    (wr_rdata)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_top.sv
`default_nettype none

// Testbench for the typed request queue.
// Requests are driven on the valid/stall input channel at the falling clock
// edge, and results are sampled on the output channel at the rising edge.
// A behavioural copy of the queue, held here, works out the results of each
// request at the moment it is accepted. The monitor then compares every
// result, field by field, with the oldest result still awaited.
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rwq_pkg::*;

    // Codes that lie outside the package's named values but that the ports allow.
    localparam logic [1:0] OP_SPARE   = 2'd3;
    localparam logic [1:0] KIND_SPARE = 2'd3;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam int MAIN_Q  = 0;
    localparam int WRITE_Q = 1;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int HOLD_CYCLES  = 250;
    localparam int MAX_REPORTS  = 30;
    localparam int REG_SETTLE   = 4;
    localparam int END_SETTLE   = 40;
    localparam int PHASES       = 6;
    localparam int PHASE_ITEMS  = 17;

    localparam bit FIXED     = 1'b1;
    localparam bit PREDICTED = 1'b0;

    // One line of stimulus: either a register write or a request. Rows marked
    // FIXED carry the status of their single result, typed in by hand.
    typedef struct packed {
        bit          is_reg;
        logic        reg_idx;
        logic [6:0]  reg_val;
        logic [1:0]  op;
        logic [1:0]  kind;
        logic [31:0] data;
        logic [4:0]  maxp;
        logic [1:0]  nstate;
        bit          fixed;
        logic [2:0]  fixed_stat;
    } step_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] data;
        logic        valid;
        logic [2:0]  stat;
        logic        last;
    } result_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  op;
    logic [1:0]  elem_kind;
    logic [31:0] payload;
    logic [4:0]  max_pull;
    logic [1:0]  new_state;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  out_kind;
    logic [31:0] out_payload;
    logic        item_valid;
    logic [2:0]  status;
    logic        last;
    logic        cfg_we;
    logic        cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // The predictor's own copy of the queues, the service state and the
    // configuration. Index MAIN_Q is the main queue, WRITE_Q the write queue.
    logic [1:0]  held_kind [2][DEPTH];
    logic [31:0] held_data [2][DEPTH];
    int          held_head [2] = '{0, 0};
    int          held_count [2] = '{0, 0};
    logic [1:0]  svc_state = SVC_IDLE;
    logic [1:0]  cur_mode  = MODE_EXCL;
    logic [6:0]  cur_slots = 7'd64;

    result_t outcome_q[$];        // results of the request being predicted
    result_t pending_results[$];  // results awaited from the block, oldest first

    int  mismatches   = 0;
    int  results_seen = 0;
    int  cycle_count  = 0;
    int  stall_left   = 0;
    int  hold_left    = 0;
    bit  hold_req     = 0;
    bit  quiet_in     = 0;
    bit  quiet_out    = 0;

    reader_writer_request_queue_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .op          (op),
        .elem_kind   (elem_kind),
        .payload     (payload),
        .max_pull    (max_pull),
        .new_state   (new_state),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_kind    (out_kind),
        .out_payload (out_payload),
        .item_valid  (item_valid),
        .status      (status),
        .last        (last),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #5 clk = ~clk;

    // A slot limit of zero behaves as one, and anything above the depth as
    // the depth itself.
    function automatic int slots_in_force();
        int n;
        n = int'(cur_slots);
        if (n == 0)
            n = 1;
        if (n > DEPTH)
            n = DEPTH;
        return n;
    endfunction

    function automatic logic [2:0] enqueue_entry(input int qi, input logic [1:0] kind,
                                                 input logic [31:0] data);
        int idx;
        if (held_count[qi] >= slots_in_force())
            return STAT_FULL;
        idx = (held_head[qi] + held_count[qi]) % DEPTH;
        held_kind[qi][idx] = kind;
        held_data[qi][idx] = data;
        held_count[qi] = held_count[qi] + 1;
        return STAT_OK;
    endfunction

    // Takes entries from the head of one queue until the pull is full, the
    // queue is empty or, unless any kind will do, an entry of another kind
    // stands at the head.
    function automatic void pop_run(input int qi, input bit any_kind,
                                    input logic [1:0] want, input int limit);
        result_t r;
        while (outcome_q.size() < limit && outcome_q.size() < MAX_BURST
               && held_count[qi] > 0)
        begin
            if (!any_kind && held_kind[qi][held_head[qi]] != want)
                break;
            r.kind  = held_kind[qi][held_head[qi]];
            r.data  = held_data[qi][held_head[qi]];
            r.valid = 1'b1;
            r.stat  = STAT_OK;
            r.last  = 1'b0;
            outcome_q.push_back(r);
            held_head[qi]  = (held_head[qi] + 1) % DEPTH;
            held_count[qi] = held_count[qi] - 1;
        end
    endfunction

    // Works out every result of one accepted request into outcome_q and
    // updates the predictor's state to match.
    function automatic void queue_outcome(input step_t s);
        logic [2:0] code;
        int         limit;
        result_t    r;
        outcome_q.delete();
        code = STAT_OK;
        case (s.op)
            OP_PULL:
            begin
                code  = STAT_NONE;
                limit = int'(s.maxp);
                if (limit > slots_in_force())
                    limit = slots_in_force();
                if (limit > MAX_BURST)
                    limit = MAX_BURST;
                if (limit != 0)
                begin
                    case (cur_mode)
                        MODE_EXCL:
                            if (svc_state != SVC_LOCK)
                                pop_run(MAIN_Q, 1'b1, KIND_EXCL, 1);
                        MODE_INORDER:
                            if (svc_state == SVC_IDLE)
                            begin
                                // The head goes out alone unless it is a read,
                                // in which case the reads behind it follow.
                                pop_run(MAIN_Q, 1'b1, KIND_EXCL, 1);
                                if (outcome_q.size() == 1 && limit > 1
                                    && outcome_q[0].kind == KIND_READ)
                                    pop_run(MAIN_Q, 1'b0, KIND_READ, limit);
                            end
                            else if (svc_state == SVC_READ)
                                pop_run(MAIN_Q, 1'b0, KIND_READ, limit);
                        MODE_WFIRST:
                        begin
                            if (held_count[WRITE_Q] > 0)
                                pop_run(WRITE_Q, 1'b0, KIND_WRITE, 1);
                            if (outcome_q.size() == 0)
                                pop_run(MAIN_Q, 1'b0, KIND_READ, limit);
                        end
                        default: ;
                    endcase
                end
            end
            OP_PUSH:
                case (cur_mode)
                    MODE_EXCL:
                        if (s.kind == KIND_EXCL)
                            code = enqueue_entry(MAIN_Q, s.kind, s.data);
                        else
                            code = STAT_KIND;
                    MODE_INORDER:
                        if (s.kind == KIND_READ || s.kind == KIND_WRITE)
                            code = enqueue_entry(MAIN_Q, s.kind, s.data);
                        else
                            code = STAT_KIND;
                    MODE_WFIRST:
                        if (s.kind == KIND_READ)
                            code = enqueue_entry(MAIN_Q, s.kind, s.data);
                        else if (s.kind == KIND_WRITE)
                            code = enqueue_entry(WRITE_Q, s.kind, s.data);
                        else
                            code = STAT_KIND;
                    default:
                        code = STAT_KIND;
                endcase
            OP_SET:
                case (cur_mode)
                    MODE_EXCL:
                        if (s.nstate == SVC_IDLE || s.nstate == SVC_LOCK)
                            svc_state = s.nstate;
                        else
                            code = STAT_STATE;
                    MODE_INORDER, MODE_WFIRST:
                        if (s.nstate != SVC_LOCK)
                            svc_state = s.nstate;
                        else
                            code = STAT_STATE;
                    default:
                        code = STAT_STATE;
                endcase
            default:
                code = STAT_KIND;
        endcase
        if (outcome_q.size() == 0)
        begin
            r = '{2'd0, 32'd0, 1'b0, code, 1'b0};
            outcome_q.push_back(r);
        end
        outcome_q[outcome_q.size() - 1].last = 1'b1;
    endfunction

    function automatic step_t req_row(input logic [1:0] o, input logic [1:0] k,
                                      input logic [31:0] d, input logic [4:0] m,
                                      input logic [1:0] ns, input bit fx,
                                      input logic [2:0] st);
        step_t s;
        s = '0;
        s.op = o;
        s.kind = k;
        s.data = d;
        s.maxp = m;
        s.nstate = ns;
        s.fixed = fx;
        s.fixed_stat = st;
        return s;
    endfunction

    function automatic step_t reg_row(input logic idx, input logic [6:0] val);
        step_t s;
        s = '0;
        s.is_reg = 1'b1;
        s.reg_idx = idx;
        s.reg_val = val;
        return s;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches = mismatches + 1;
        if (mismatches <= MAX_REPORTS)
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    // Waits until every awaited result has arrived, then lets the given settle time pass.
    task automatic wait_drained(input int settle);
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (settle) @(negedge clk);
    endtask

    // Register writes happen only once the block has nothing in flight.
    task automatic write_reg(input logic idx, input logic [6:0] val);
        in_valid = 1'b0;
        wait_drained(REG_SETTLE);
        cfg_index = idx;
        cfg_data  = val;
        cfg_we    = 1'b1;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_QUEUE_MODE)
            cur_mode = val[1:0];
        else
            cur_slots = val;
    endtask

    // Offers one request, after a random gap unless quiet_in is set, and holds it until accepted.
    // Called and left at a falling edge; valid stays high when no gap follows.
    task automatic send_request(input step_t s);
        int      gap;
        result_t r;
        gap = quiet_in ? 0 : $urandom_range(0, 17);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op        = s.op;
        elem_kind = s.kind;
        payload   = s.data;
        max_pull  = s.maxp;
        new_state = s.nstate;
        in_valid  = 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        queue_outcome(s);
        if (s.fixed)
        begin
            r = '{2'd0, 32'd0, 1'b0, s.fixed_stat, 1'b1};
            pending_results.push_back(r);
        end
        else
        begin
            foreach (outcome_q[j])
                pending_results.push_back(outcome_q[j]);
        end
        @(negedge clk);
    endtask

    // Result monitor: every accepted result is matched against the oldest
    // awaited one. The receiver's next stall is drawn here as well.
    always @(posedge clk)
    begin : monitor
        result_t want;
        if (rst_n && out_valid === 1'b1 && !out_stall)
        begin
            results_seen = results_seen + 1;
            if (pending_results.size() == 0)
                report_mismatch("result with none awaited", out_payload, 32'd0);
            else
            begin
                want = pending_results.pop_front();
                if (out_kind !== want.kind)
                    report_mismatch("out_kind", 32'(out_kind), 32'(want.kind));
                if (out_payload !== want.data)
                    report_mismatch("out_payload", out_payload, want.data);
                if (item_valid !== want.valid)
                    report_mismatch("item_valid", 32'(item_valid), 32'(want.valid));
                if (status !== want.stat)
                    report_mismatch("status field", 32'(status), 32'(want.stat));
                if (last !== want.last)
                    report_mismatch("last", 32'(last), 32'(want.last));
            end
            // Now and then the receiver switches between stalling at random
            // and taking every result at once.
            if (results_seen % 24 == 0)
                quiet_out = ($urandom_range(0, 2) == 0);
            stall_left = quiet_out ? 0 : $urandom_range(0, 17);
        end
    end

    // Receiver: stalls for the drawn number of cycles before each result, and
    // once holds off for a long stretch so that the block backs up and stalls
    // its own input while requests keep being offered.
    initial
    begin : receiver
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall = 1'b1;
                hold_left = hold_left - 1;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left = stall_left - 1;
            end
            else
                out_stall = 1'b0;
        end
    end

    // Watchdog: a hung block or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        step_t      dir_tab[$];
        step_t      s;
        int         ph;
        int         i;
        int         r;
        logic [1:0] ph_mode;
        logic [6:0] ph_slots;

        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        op        = OP_PUSH;
        elem_kind = KIND_EXCL;
        payload   = 32'd0;
        max_pull  = 5'd0;
        new_state = SVC_IDLE;
        cfg_we    = 1'b0;
        cfg_index = CFG_QUEUE_MODE;
        cfg_data  = '0;

        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. After reset the block is in exclusive mode with a
        // slot limit of 64 and an idle service state.
        dir_tab = '{
            // Nothing queued yet, so a pull gives nothing.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd1, SVC_IDLE, FIXED, STAT_NONE),
            req_row(OP_PUSH, KIND_EXCL, 32'hFFFF_FFFF, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            req_row(OP_PUSH, KIND_EXCL, 32'h0000_0000, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            // Exclusive mode takes exclusive entries only.
            req_row(OP_PUSH, KIND_READ, 32'h0000_0001, 5'd0, SVC_IDLE, FIXED, STAT_KIND),
            // Read and write states are refused in exclusive mode.
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_READ, FIXED, STAT_STATE),
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_LOCK, FIXED, STAT_OK),
            // While locked, nothing comes out.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd16, SVC_IDLE, FIXED, STAT_NONE),
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            // A large pull size still gives one entry in exclusive mode.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd31, SVC_IDLE, PREDICTED, STAT_OK),
            // A pull size of zero pulls nothing.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd0, SVC_IDLE, FIXED, STAT_NONE),
            // The unused operation is answered as a bad kind.
            req_row(OP_SPARE, KIND_SPARE, 32'hDEAD_BEEF, 5'd31, SVC_WRITE, FIXED, STAT_KIND),
            // Leave the lock set for the in-order phase.
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_LOCK, FIXED, STAT_OK),
            reg_row(CFG_QUEUE_MODE, {5'd0, MODE_INORDER}),
            reg_row(CFG_SLOT_LIMIT, 7'd3),
            req_row(OP_PUSH, KIND_READ, 32'hA5A5_A5A5, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            // A lock left over from exclusive mode blocks every pull.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd4, SVC_IDLE, FIXED, STAT_NONE),
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            // The exclusive entry left over at the head goes out alone,
            // then the read behind it.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd5, SVC_IDLE, PREDICTED, STAT_OK),
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd5, SVC_IDLE, PREDICTED, STAT_OK),
            // In the write state an in-order pull gives nothing.
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_WRITE, FIXED, STAT_OK),
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd2, SVC_IDLE, FIXED, STAT_NONE),
            reg_row(CFG_QUEUE_MODE, {5'd0, MODE_WFIRST}),
            reg_row(CFG_SLOT_LIMIT, 7'd1),
            req_row(OP_PUSH, KIND_WRITE, 32'h5A5A_5A5A, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            // The write queue holds one entry at this slot limit.
            req_row(OP_PUSH, KIND_WRITE, 32'h0000_0002, 5'd0, SVC_IDLE, FIXED, STAT_FULL),
            req_row(OP_PUSH, KIND_READ, 32'h1234_5678, 5'd0, SVC_IDLE, FIXED, STAT_OK),
            // The write is served before the read.
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd16, SVC_IDLE, PREDICTED, STAT_OK),
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd16, SVC_IDLE, PREDICTED, STAT_OK),
            // The unused mode refuses every request.
            reg_row(CFG_QUEUE_MODE, {5'd0, MODE_SPARE}),
            req_row(OP_PUSH, KIND_READ, 32'd0, 5'd0, SVC_IDLE, FIXED, STAT_KIND),
            req_row(OP_PULL, KIND_EXCL, 32'd0, 5'd8, SVC_IDLE, FIXED, STAT_NONE),
            req_row(OP_SET, KIND_EXCL, 32'd0, 5'd0, SVC_IDLE, FIXED, STAT_STATE)
        };

        foreach (dir_tab[k])
        begin
            if (dir_tab[k].is_reg)
                write_reg(dir_tab[k].reg_idx, dir_tab[k].reg_val);
            else
                send_request(dir_tab[k]);
        end

        // Random part: a run of phases, each with its own mode and slot limit.
        // Most requests suit the mode so that the queues fill and runs of
        // reads build up; the rest are refused kinds, refused states and odd
        // pull sizes.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin ph_mode = MODE_INORDER; ph_slots = 7'd4;   end
                1:       begin ph_mode = MODE_WFIRST;  ph_slots = 7'd127; end
                2:       begin ph_mode = MODE_EXCL;    ph_slots = 7'd0;   end
                3:       begin ph_mode = MODE_INORDER; ph_slots = 7'd64;  end
                4:       begin ph_mode = MODE_WFIRST;  ph_slots = 7'd2;   end
                default:
                begin
                    ph_mode  = 2'($urandom_range(0, 2));
                    ph_slots = 7'($urandom_range(1, 16));
                end
            endcase
            write_reg(CFG_QUEUE_MODE, {5'd0, ph_mode});
            write_reg(CFG_SLOT_LIMIT, ph_slots);
            quiet_in = ($urandom_range(0, 3) == 0);

            for (i = 0; i < PHASE_ITEMS; i++)
            begin
                // Part way through one phase the receiver holds off for long.
                if (ph == 1 && i == 8)
                    hold_req = 1'b1;
                s = '0;
                r = $urandom_range(0, 99);
                if (r < 45)
                    s.op = OP_PUSH;
                else if (r < 80)
                    s.op = OP_PULL;
                else if (r < 96)
                    s.op = OP_SET;
                else
                    s.op = OP_SPARE;

                r = $urandom_range(0, 99);
                case (ph_mode)
                    MODE_EXCL:
                        s.kind = (r < 80) ? KIND_EXCL : 2'($urandom_range(0, 3));
                    default:
                        if (r < 55)
                            s.kind = KIND_READ;
                        else if (r < 85)
                            s.kind = KIND_WRITE;
                        else
                            s.kind = 2'($urandom_range(0, 3));
                endcase

                r = $urandom_range(0, 99);
                if (ph_mode == MODE_EXCL)
                begin
                    if (r < 55)
                        s.nstate = SVC_IDLE;
                    else if (r < 85)
                        s.nstate = SVC_LOCK;
                    else
                        s.nstate = 2'($urandom_range(0, 3));
                end
                else
                begin
                    if (r < 45)
                        s.nstate = SVC_IDLE;
                    else if (r < 75)
                        s.nstate = SVC_READ;
                    else if (r < 88)
                        s.nstate = SVC_WRITE;
                    else
                        s.nstate = 2'($urandom_range(0, 3));
                end

                r = $urandom_range(0, 99);
                if (r < 80)
                    s.maxp = 5'($urandom_range(1, 16));
                else if (r < 92)
                    s.maxp = 5'($urandom_range(17, 31));
                else
                    s.maxp = 5'd0;

                r = $urandom_range(0, 15);
                if (r == 0)
                    s.data = 32'h0000_0000;
                else if (r == 1)
                    s.data = 32'hFFFF_FFFF;
                else
                    s.data = $urandom();

                send_request(s);
            end
        end

        in_valid = 1'b0;
        wait_drained(END_SETTLE);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/rwq_pkg.sv
rtl/rwq_ram.sv
rtl/rwq_ctrl.sv
rtl/reader_writer_request_queue_core.sv
tb/sv/tb_top.sv
